>>> src/fr_pkg.sv
// shared types and constants for the fraction reducer
package fr_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int SHIFT_WIDTH = $clog2(VALUE_WIDTH);

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] numerator_in;
        logic [VALUE_WIDTH-1:0] denominator_in;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] numerator_out;
        logic [VALUE_WIDTH-1:0] denominator_out;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic num_zero;
        logic gcd_done;
    } t_status;

endpackage

>>> src/fraction_reducer.sv
// top level of the fraction reducer: controller plus datapath
//
// reduces a nonnegative fraction to lowest terms by dividing numerator
// and denominator by their greatest common divisor
// input channel: i_in_valid / o_in_stall with i_in_data; a transfer happens
//   on a rising edge with valid high and stall low
// output channel: o_out_valid / i_out_stall with o_out_data, same rule
// one item is in flight at a time; each item gives exactly one result
// after the input transfer an item passes the binary gcd steps, the gcd exit
//   check, the divisor setup, the divider steps and the load into the
//   result register, in that order
// a zero numerator skips gcd and division and goes to the result register
// the next input transfer can come in the cycle after the result register
//   is loaded, so the gcd loop and the dividers set the rate
// the result register parts the two channels: a new item is taken while a
//   finished result waits, and a stalled result holds its value
// a finished item waits for a stalled result to leave; input stays stalled
// synchronous active-low reset empties the block; no result is pending
module fraction_reducer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  fr_pkg::t_in_item  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output fr_pkg::t_out_item o_out_data
);

    fr_pkg::t_cmd    w_cmd;
    fr_pkg::t_status w_status;

    // sequencing of load, gcd loop, divider and result transfer
    fr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // operand registers, gcd unit, dividers and result register
    fr_dpath u_dpath (
        .i_clk      (i_clk),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_data (o_out_data)
    );

endmodule

>>> src/fr_dpath.sv
// datapath of the fraction reducer: binary gcd and two restoring dividers
module fr_dpath (
    input  logic             i_clk,
    input  fr_pkg::t_in_item i_in_data,
    input  fr_pkg::t_cmd     i_cmd,
    output fr_pkg::t_status  o_status,
    output fr_pkg::t_out_item o_out_data
);

    localparam int W  = fr_pkg::VALUE_WIDTH;
    localparam int SW = fr_pkg::SHIFT_WIDTH;

    logic [W-1:0]  r_num, r_den;
    logic [W-1:0]  r_a, r_b;
    logic [SW-1:0] r_k;
    logic [W-1:0]  r_g;
    logic [W-1:0]  r_rn, r_rd;
    fr_pkg::t_out_item r_out;

    logic [W:0]   w_tn, w_td;
    logic         w_qn, w_qd;

    assign o_status.num_zero = (r_num == '0);
    assign o_status.gcd_done = (r_a == '0) || (r_b == '0);
    assign o_out_data        = r_out;

    // trial subtract of the shifted remainder against the divisor
    assign w_tn = {r_rn, r_a[W-1]};
    assign w_td = {r_rd, r_b[W-1]};
    assign w_qn = (w_tn >= {1'b0, r_g});
    assign w_qd = (w_td >= {1'b0, r_g});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num <= i_in_data.numerator_in;
            r_den <= i_in_data.denominator_in;
            r_a   <= i_in_data.numerator_in;
            r_b   <= i_in_data.denominator_in;
            r_k   <= '0;
        end else if (i_cmd.gcd_step) begin
            if (!r_a[0] && !r_b[0]) begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= SW'(r_k + 1'b1);
            end else if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (r_a >= r_b) begin
                r_a <= r_a - r_b;
            end else begin
                r_b <= r_b - r_a;
            end
        end else if (i_cmd.div_init) begin
            // one of a, b is zero here; the other, shifted left by k, is the gcd
            r_g  <= (r_a | r_b) << r_k;
            r_a  <= r_num;
            r_b  <= r_den;
            r_rn <= '0;
            r_rd <= '0;
        end else if (i_cmd.div_step) begin
            r_rn <= w_qn ? W'(w_tn - {1'b0, r_g}) : w_tn[W-1:0];
            r_rd <= w_qd ? W'(w_td - {1'b0, r_g}) : w_td[W-1:0];
            r_a  <= {r_a[W-2:0], w_qn};
            r_b  <= {r_b[W-2:0], w_qd};
        end

        if (i_cmd.out_load) begin
            if (r_num == '0) begin
                r_out.numerator_out   <= r_num;
                r_out.denominator_out <= r_den;
            end else begin
                r_out.numerator_out   <= r_a;
                r_out.denominator_out <= r_b;
            end
        end
    end

endmodule

>>> src/fr_ctrl.sv
// controller state machine of the fraction reducer
module fr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  fr_pkg::t_status i_status,
    output fr_pkg::t_cmd    o_cmd
);

    localparam int W  = fr_pkg::VALUE_WIDTH;
    localparam int SW = fr_pkg::SHIFT_WIDTH;
    localparam logic [SW-1:0] LAST = SW'(W - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GCD  = 3'd1;
    localparam logic [2:0] S_INIT = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [SW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          w_out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_GCD;
                end
            end
            S_GCD: begin
                if (i_status.num_zero) begin
                    n_state = S_OUT;
                end else if (i_status.gcd_done) begin
                    n_state = S_INIT;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_INIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = SW'(r_cnt + 1'b1);
                if (r_cnt == LAST) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    a_valid_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_out_valid) |-> $past(!i_out_stall))
        else $error("result dropped without transfer");

    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == LAST) |=> (r_state == S_OUT))
        else $error("divider did not finish after full width");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not presented");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= LAST))
        else $error("divide counter out of range");

endmodule

>>> verif/testbench.sv
// self-checking testbench for the fraction reducer
module testbench;
    import fr_pkg::*;

    typedef logic [VALUE_WIDTH-1:0] value_t;

    localparam value_t      ALL_ONES     = '1;
    localparam longint      VALUE_MAX    = (longint'(1) << VALUE_WIDTH) - 1;
    localparam int unsigned RANDOM_ITEMS = 1430;
    // receiver hold-off, longer than one worst-case item so the block backs up
    localparam int unsigned HOLD_CYCLES  = 400;
    // worst item plus hold-off plus sender gap, with wide margin
    localparam int unsigned IDLE_LIMIT   = 5000;
    // one worst-case item latency with margin
    localparam int unsigned DRAIN_CYCLES = 200;

    // expected reductions in arrival order; the block gives one result per item
    class fraction_scoreboard;
        t_out_item   reduced_q[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        // divide both parts by their gcd (euclid); a zero numerator passes through
        static function t_out_item reduce_fraction(t_in_item frac);
            value_t    a;
            value_t    b;
            value_t    r;
            t_out_item res;
            res.numerator_out   = frac.numerator_in;
            res.denominator_out = frac.denominator_in;
            if (frac.numerator_in != '0) begin
                a = frac.numerator_in;
                b = frac.denominator_in;
                while (b != '0) begin
                    r = a % b;
                    a = b;
                    b = r;
                end
                res.numerator_out   = frac.numerator_in / a;
                res.denominator_out = frac.denominator_in / a;
            end
            return res;
        endfunction

        function int unsigned pending();
            return reduced_q.size();
        endfunction

        task report(string msg);
            $display("error at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task note_fraction(t_in_item frac);
            reduced_q.push_back(reduce_fraction(frac));
        endtask

        task check_reduced(t_out_item got);
            t_out_item want;
            if (reduced_q.size() == 0) begin
                report($sformatf("unexpected result %0d/%0d",
                                 got.numerator_out, got.denominator_out));
                return;
            end
            want = reduced_q.pop_front();
            if (got.numerator_out !== want.numerator_out)
                report($sformatf("numerator got %0d expected %0d",
                                 got.numerator_out, want.numerator_out));
            if (got.denominator_out !== want.denominator_out)
                report($sformatf("denominator got %0d expected %0d",
                                 got.denominator_out, want.denominator_out));
        endtask

        task check_leftover();
            if (reduced_q.size() != 0)
                report($sformatf("%0d results never arrived", reduced_q.size()));
        endtask
    endclass

    logic      i_clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;

    // set by the sender, taken and cleared by the receiver
    bit          hold_req = 1'b0;
    int unsigned idle_cycles = 0;

    fraction_scoreboard sb = new();

    always #5 i_clk = ~i_clk;

    fraction_reducer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // monitors: all values read here are the ones present just before the edge
    always @(posedge i_clk) begin
        if (rst_n === 1'b1 && in_valid && in_stall === 1'b0)
            sb.note_fraction(in_data);
        if (rst_n === 1'b1 && out_valid === 1'b1 && !out_stall)
            sb.check_reduced(out_data);
        // watchdog bookkeeping: any transfer on either side counts as progress
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        $display("Mismatches found");
        $finish;
    end

    // one input transfer: hold valid and data until the block takes them
    task automatic send_fraction(input t_in_item frac);
        in_valid <= 1'b1;
        in_data  <= frac;
        @(posedge i_clk);
        while (in_stall !== 1'b0)
            @(posedge i_clk);
    endtask

    task automatic idle_input(input int unsigned cycles);
        if (cycles != 0) begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // drop valid and wait until every expected reduction has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // random fractions, mostly shaped so the gcd is nontrivial
    function automatic t_in_item random_fraction();
        t_in_item    frac;
        longint      g;
        longint      a;
        longint      b;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        frac.numerator_in   = value_t'($urandom);
        frac.denominator_in = value_t'($urandom);
        case (sel)
            3, 4: begin
                // shared factor, from small to about 2^16
                g = $urandom_range(2, 1 << $urandom_range(1, 16));
                a = $urandom_range(0, 32'(VALUE_MAX / g));
                b = $urandom_range(0, 32'(VALUE_MAX / g));
                frac.numerator_in   = value_t'(a * g);
                frac.denominator_in = value_t'(b * g);
            end
            5: begin
                // power-of-two factors, always on the numerator, exercises the shift steps
                frac.numerator_in   = value_t'($urandom) << $urandom_range(1, 30);
                frac.denominator_in = value_t'($urandom) << $urandom_range(0, 30);
            end
            6: begin
                // zero numerator passes through; zero denominator gives 1/0
                if ($urandom_range(0, 1) == 0)
                    frac.numerator_in = '0;
                else
                    frac.denominator_in = '0;
            end
            7: begin
                frac.numerator_in   = value_t'($urandom_range(0, 15));
                frac.denominator_in = value_t'($urandom_range(0, 15));
            end
            8: begin
                // denominator one, or equal parts
                if ($urandom_range(0, 1) == 0)
                    frac.denominator_in = value_t'(1);
                else
                    frac.denominator_in = frac.numerator_in;
            end
            9: begin
                // one part an exact multiple of the other
                b = $urandom_range(1, 1 << 20);
                a = b * $urandom_range(1, 32'(VALUE_MAX / b));
                if ($urandom_range(0, 1) == 0) begin
                    frac.numerator_in   = value_t'(b);
                    frac.denominator_in = value_t'(a);
                end else begin
                    frac.numerator_in   = value_t'(a);
                    frac.denominator_in = value_t'(b);
                end
            end
            default: ;
        endcase
        return frac;
    endfunction

    // receiver: switches between random stall patterns, honors hold-off
    initial begin : receiver
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned tick;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 99) < 30);
                    2: out_stall <= ($urandom_range(0, 99) < 80);
                    default: out_stall <= ((tick % 5) < 2);
                endcase
            end
        end
    end

    // sender: directed corner cases, then random bursts with gaps
    initial begin : stimulus
        t_in_item    frac;
        int unsigned burst_left;
        int unsigned gap;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        for (int k = 0; k < 22; k++) begin
            case (k)
                0:  frac = {value_t'(0), value_t'(0)};
                1:  frac = {value_t'(0), value_t'(5)};
                2:  frac = {value_t'(0), ALL_ONES};
                3:  frac = {ALL_ONES, value_t'(0)};
                4:  frac = {value_t'(5), value_t'(0)};
                5:  frac = {value_t'(1), value_t'(0)};
                6:  frac = {ALL_ONES, ALL_ONES};
                7:  frac = {ALL_ONES, value_t'(1)};
                8:  frac = {value_t'(1), value_t'(1)};
                9:  frac = {value_t'(1), ALL_ONES};
                10: frac = {value_t'(12), value_t'(18)};
                11: frac = {ALL_ONES, ALL_ONES - value_t'(1)};
                12: frac = {value_t'(1073741824), value_t'(1073741824)};
                13: frac = {value_t'(1073741824), value_t'(536870912)};
                14: frac = {value_t'(6), value_t'(4)};
                // power of two against a power of three: coprime
                15: frac = {value_t'(1073741824), value_t'(1162261467)};
                // consecutive fibonacci numbers: long remainder chain
                16: frac = {value_t'(1836311903), value_t'(1134903170)};
                17: frac = {value_t'(2147483646), value_t'(1073741823)};
                18: frac = {value_t'(2147483646), value_t'(2)};
                19: frac = {value_t'(1073741824), value_t'(3)};
                20: frac = {value_t'(6356992), value_t'(291)};
                default: frac = {value_t'(7), value_t'(1)};
            endcase
            send_fraction(frac);
        end
        drain_results();

        burst_left = 0;
        for (int unsigned sent = 0; sent < RANDOM_ITEMS; sent++) begin
            // long receiver hold-off while the sender keeps offering items
            if (sent == 300)
                hold_req = 1'b1;
            // sender pauses until the block has returned everything
            if (sent == 700 || sent == 1100)
                drain_results();
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                idle_input(gap);
                burst_left = ($urandom_range(0, 7) == 0) ? 50 : $urandom_range(1, 12);
            end
            send_fraction(random_fraction());
            burst_left--;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.check_leftover();
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
